@@ src/icr_pkg.sv @@
package icr_pkg;

	// orbital table geometry
	localparam int MAX_ORBITALS = 256;
	localparam int ADDR_W       = $clog2(MAX_ORBITALS);

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// permutation rows and destination classes
	localparam int NUM_ROWS = 16;
	localparam int ROW_W    = $clog2(NUM_ROWS);
	localparam int NUM_CLS  = 6;

	localparam logic [2:0] CLS_A = 3'd0; // oo|oo
	localparam logic [2:0] CLS_B = 3'd1; // vv|vv
	localparam logic [2:0] CLS_C = 3'd2; // oo|vv
	localparam logic [2:0] CLS_D = 3'd3; // ov|ov
	localparam logic [2:0] CLS_E = 3'd4; // vo|oo
	localparam logic [2:0] CLS_F = 3'd5; // ov|vv

	localparam logic ACT_CLASSIFY = 1'b0;
	localparam logic ACT_LOAD     = 1'b1;

	typedef struct packed {
		logic        action;
		logic [7:0]  index_first;
		logic [7:0]  index_second;
		logic [7:0]  index_third;
		logic [7:0]  index_fourth;
		logic [63:0] integral_bits;
		logic [7:0]  load_orbital;
		logic        load_occupied;
		logic        load_virtual;
		logic        load_singly_occupied;
		logic [7:0]  load_occ_position;
		logic [7:0]  load_vir_position;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  integral_class;
		logic [7:0]  out_index_first;
		logic [7:0]  out_index_second;
		logic [7:0]  out_index_third;
		logic [7:0]  out_index_fourth;
		logic [63:0] out_integral_bits;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic       occupied;
		logic       virt;
		logic       single;
		logic [7:0] occ_pos;
		logic [7:0] vir_pos;
	} orb_entry_t;

	// classified transaction waiting for the back end
	typedef struct packed {
		logic [NUM_ROWS-1:0] mask;
		logic [0:3][7:0]     occ_pos;
		logic [0:3][7:0]     vir_pos;
		logic [63:0]         bits;
	} q_entry_t;

	typedef struct packed {
		logic [2:0]      cls;
		logic [0:3][1:0] slot;
		logic [0:3]      is_vir;
	} perm_row_t;

	function automatic perm_row_t perm_row(input logic [ROW_W-1:0] k);
		perm_row_t r;
		case (k)
			4'd0:    r = '{CLS_A, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b0000};
			4'd1:    r = '{CLS_B, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b1111};
			4'd2:    r = '{CLS_C, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b0011};
			4'd3:    r = '{CLS_C, {2'd2, 2'd3, 2'd0, 2'd1}, 4'b0011};
			4'd4:    r = '{CLS_D, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b0101};
			4'd5:    r = '{CLS_D, {2'd1, 2'd0, 2'd2, 2'd3}, 4'b0101};
			4'd6:    r = '{CLS_D, {2'd0, 2'd1, 2'd3, 2'd2}, 4'b0101};
			4'd7:    r = '{CLS_D, {2'd1, 2'd0, 2'd3, 2'd2}, 4'b0101};
			4'd8:    r = '{CLS_E, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b1000};
			4'd9:    r = '{CLS_E, {2'd1, 2'd0, 2'd2, 2'd3}, 4'b1000};
			4'd10:   r = '{CLS_E, {2'd2, 2'd3, 2'd0, 2'd1}, 4'b1000};
			4'd11:   r = '{CLS_E, {2'd3, 2'd2, 2'd0, 2'd1}, 4'b1000};
			4'd12:   r = '{CLS_F, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b0111};
			4'd13:   r = '{CLS_F, {2'd1, 2'd0, 2'd2, 2'd3}, 4'b0111};
			4'd14:   r = '{CLS_F, {2'd2, 2'd3, 2'd0, 2'd1}, 4'b0111};
			4'd15:   r = '{CLS_F, {2'd3, 2'd2, 2'd0, 2'd1}, 4'b0111};
			default: r = '{CLS_A, {2'd0, 2'd1, 2'd2, 2'd3}, 4'b0000};
		endcase
		return r;
	endfunction

endpackage

@@ src/icr_front.sv @@
module icr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  icr_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_wr,
	output icr_pkg::q_entry_t q_data
);

	// two table copies, two read ports each: four lookups a cycle unless stalled
	icr_pkg::orb_entry_t mem_a_q [icr_pkg::MAX_ORBITALS];
	icr_pkg::orb_entry_t mem_b_q [icr_pkg::MAX_ORBITALS];

	icr_pkg::orb_entry_t      rd_s1 [4];
	logic [3:0]               in_range_s1;
	logic [63:0]              bits_s1;
	logic                     valid_s1;

	logic                     take;
	logic                     wr_ok;
	logic [3:0]               in_range;
	icr_pkg::orb_entry_t      wr_entry;
	icr_pkg::orb_entry_t      ent [4];
	logic [icr_pkg::NUM_ROWS-1:0] mask;

	assign full  = valid_s1 && q_full;
	assign take  = push && !full;
	assign wr_ok = 32'(item.load_orbital) < icr_pkg::MAX_ORBITALS;

	assign in_range[0] = 32'(item.index_first)  < icr_pkg::MAX_ORBITALS;
	assign in_range[1] = 32'(item.index_second) < icr_pkg::MAX_ORBITALS;
	assign in_range[2] = 32'(item.index_third)  < icr_pkg::MAX_ORBITALS;
	assign in_range[3] = 32'(item.index_fourth) < icr_pkg::MAX_ORBITALS;

	assign wr_entry = '{item.load_occupied, item.load_virtual, item.load_singly_occupied,
		item.load_occ_position, item.load_vir_position};

	always_ff @(posedge clk) begin
		if (take && item.action == icr_pkg::ACT_LOAD && wr_ok) begin
			mem_a_q[icr_pkg::ADDR_W'(item.load_orbital)] <= wr_entry;
			mem_b_q[icr_pkg::ADDR_W'(item.load_orbital)] <= wr_entry;
		end
	end

	// registered reads, held while the stage is stalled
	always_ff @(posedge clk) begin
		if (!full) begin
			rd_s1[0]    <= mem_a_q[icr_pkg::ADDR_W'(item.index_first)];
			rd_s1[1]    <= mem_a_q[icr_pkg::ADDR_W'(item.index_second)];
			rd_s1[2]    <= mem_b_q[icr_pkg::ADDR_W'(item.index_third)];
			rd_s1[3]    <= mem_b_q[icr_pkg::ADDR_W'(item.index_fourth)];
			in_range_s1 <= in_range;
			bits_s1     <= item.integral_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= take && item.action == icr_pkg::ACT_CLASSIFY;
		end
	end

	// out-of-range lookups read as an empty entry
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ent[i] = in_range_s1[i] ? rd_s1[i] : '0;
		end
	end

	// pattern match per permutation, keep first per class unless several singles
	always_comb begin
		icr_pkg::perm_row_t         row;
		logic                       hit;
		logic                       multi;
		logic [icr_pkg::NUM_CLS-1:0] seen;
		multi = (2'(ent[0].single) + 2'(ent[1].single) + 2'(ent[2].single)
			+ 2'(ent[3].single) > 2'd1) || (ent[0].single && ent[1].single
			&& ent[2].single && ent[3].single);
		seen  = '0;
		mask  = '0;
		for (int k = 0; k < icr_pkg::NUM_ROWS; k++) begin
			row = icr_pkg::perm_row(icr_pkg::ROW_W'(k));
			hit = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (!(row.is_vir[i] ? ent[row.slot[i]].virt : ent[row.slot[i]].occupied)) begin
					hit = 1'b0;
				end
			end
			if (hit && (multi || !seen[row.cls])) begin
				mask[k] = 1'b1;
			end
			if (hit) begin
				seen[row.cls] = 1'b1;
			end
		end
	end

	always_comb begin
		q_data.mask = mask;
		q_data.bits = bits_s1;
		for (int i = 0; i < 4; i++) begin
			q_data.occ_pos[i] = ent[i].occ_pos;
			q_data.vir_pos[i] = ent[i].vir_pos;
		end
	end

	// items that match nothing leave here without a queue slot
	assign q_wr = valid_s1 && !q_full && (mask != '0);

	wr_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("front wrote into a full queue");

	stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> valid_s1 && $stable(bits_s1))
		else $error("stalled classify stage lost its transaction");

endmodule

@@ src/icr_queue.sv @@
module icr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  icr_pkg::q_entry_t wr_data,
	output logic              full,
	input  logic              rd,
	output logic              empty,
	output icr_pkg::q_entry_t rd_data
);

	icr_pkg::q_entry_t              slots_q [icr_pkg::Q_DEPTH];
	logic [icr_pkg::Q_PTR_W-1:0]    wptr_q;
	logic [icr_pkg::Q_PTR_W-1:0]    rptr_q;
	logic [icr_pkg::Q_CNT_W-1:0]    count_q;

	assign full    = count_q == icr_pkg::Q_CNT_W'(icr_pkg::Q_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + icr_pkg::Q_CNT_W'(wr) - icr_pkg::Q_CNT_W'(rd);
		end
	end

	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");

endmodule

@@ src/icr_back.sv @@
module icr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  icr_pkg::q_entry_t  q_data,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output icr_pkg::out_item_t result
);

	logic [icr_pkg::NUM_ROWS-1:0] done_q;
	logic                         out_valid_q;
	icr_pkg::out_item_t           out_q;

	logic [icr_pkg::NUM_ROWS-1:0] remaining;
	logic [icr_pkg::NUM_ROWS-1:0] sel_hot;
	logic [icr_pkg::ROW_W-1:0]    sel;
	logic                         emit;
	logic                         last;
	icr_pkg::perm_row_t           row;
	icr_pkg::out_item_t           nxt;

	assign remaining = q_data.mask & ~done_q;

	// lowest pending permutation goes first
	always_comb begin
		sel = '0;
		for (int k = icr_pkg::NUM_ROWS - 1; k >= 0; k--) begin
			if (remaining[k]) begin
				sel = icr_pkg::ROW_W'(k);
			end
		end
	end

	assign sel_hot = icr_pkg::NUM_ROWS'(1) << sel;
	assign last    = (remaining & ~sel_hot) == '0;
	assign emit    = !q_empty && (!out_valid_q || pop);
	assign q_rd    = emit && last;
	assign row     = icr_pkg::perm_row(sel);

	always_comb begin
		logic [0:3][7:0] idx;
		for (int i = 0; i < 4; i++) begin
			idx[i] = row.is_vir[i] ? q_data.vir_pos[row.slot[i]] : q_data.occ_pos[row.slot[i]];
		end
		nxt = '{row.cls, idx[0], idx[1], idx[2], idx[3], q_data.bits, last};
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				done_q <= last ? '0 : (done_q | sel_hot);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> remaining != '0)
		else $error("queued transaction with no permutation left");

endmodule

@@ src/integral_class_router.sv @@
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | push / full          | item   (icr_pkg::in_item_t)
// result    | empty / pop          | result (icr_pkg::out_item_t)
//
// a load transaction writes the table at its accept edge; a classify transaction
// reads all four entries at its accept edge (two dual-read table copies)
// a result passes the lookup register, queue slot and output register to the ports
// the result sequencer gives one result per cycle while the output register is free;
// a classify that matches nothing gives no result and takes no queue slot
// reset clears only control state; table contents are undefined until loaded
// full rises only when the classify stage holds a transaction and the queue is full
module integral_class_router (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  icr_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output icr_pkg::out_item_t result
);

	// front to queue
	logic              q_wr;
	logic              q_full;
	icr_pkg::q_entry_t q_wr_data;

	// queue to back
	logic              q_rd;
	logic              q_empty;
	icr_pkg::q_entry_t q_rd_data;

	// front: table, lookup and class matching
	icr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_wr_data)
	);

	// short queue decouples matching from result emission
	icr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.empty   (q_empty),
		.rd_data (q_rd_data)
	);

	// back: walks the match mask, one result per cycle while the output register is free
	icr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

	// run control
	localparam int LIMIT    = 400000; // cycle budget for the whole run
	localparam int IDLE_PCT = 16;     // idle chance per cycle on either side
	localparam int SETTLE   = 16;     // cycles allowed after the last result
	localparam int N_RANDOM = 310;

	// permutation rows: destination class, source slot per position, virtual role per position
	// slot order is two bits per position, position 0 in the top bits
	localparam logic [0:icr_pkg::NUM_ROWS-1][2:0] PERM_CLS = {
		icr_pkg::CLS_A, icr_pkg::CLS_B, icr_pkg::CLS_C, icr_pkg::CLS_C,
		icr_pkg::CLS_D, icr_pkg::CLS_D, icr_pkg::CLS_D, icr_pkg::CLS_D,
		icr_pkg::CLS_E, icr_pkg::CLS_E, icr_pkg::CLS_E, icr_pkg::CLS_E,
		icr_pkg::CLS_F, icr_pkg::CLS_F, icr_pkg::CLS_F, icr_pkg::CLS_F
	};
	localparam logic [0:icr_pkg::NUM_ROWS-1][7:0] PERM_SLOTS = {
		8'h1B, 8'h1B, 8'h1B, 8'hB1,
		8'h1B, 8'h4B, 8'h1E, 8'h4E,
		8'h1B, 8'h4B, 8'hB1, 8'hE1,
		8'h1B, 8'h4B, 8'hB1, 8'hE1
	};
	localparam logic [0:icr_pkg::NUM_ROWS-1][3:0] PERM_VIR = {
		4'b0000, 4'b1111, 4'b0011, 4'b0011,
		4'b0101, 4'b0101, 4'b0101, 4'b0101,
		4'b1000, 4'b1000, 4'b1000, 4'b1000,
		4'b0111, 4'b0111, 4'b0111, 4'b0111
	};

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                push   = 1'b0;
	logic                full;
	icr_pkg::in_item_t   item   = '0;
	logic                empty;
	logic                pop    = 1'b0;
	icr_pkg::out_item_t  result;

	// mirror of the orbital table and what has been written so far
	icr_pkg::orb_entry_t orb_table [icr_pkg::MAX_ORBITALS];
	bit                  orb_loaded [icr_pkg::MAX_ORBITALS];
	logic [7:0]          loaded_orbitals [$];

	// results still owed by the block, oldest first
	icr_pkg::out_item_t  results_due [$];

	int errors       = 0;
	int cycles       = 0;
	bit quiet        = 1'b0; // no idling on either side while set
	int stall_cycles = 0;    // receiver hold-off, counted down by the receiver

	always #2 clk = ~clk;

	integral_class_router u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// route one classify transaction into the expected results
	function automatic void route_integral(input icr_pkg::in_item_t it);
		logic [7:0]                  idx [4];
		icr_pkg::orb_entry_t         ent [4];
		logic [7:0]                  pos [4];
		icr_pkg::out_item_t          run [icr_pkg::NUM_ROWS];
		logic [icr_pkg::NUM_CLS-1:0] cls_seen;
		logic [1:0]                  sl;
		int                          singles;
		int                          n;
		bit                          multi;
		bit                          hit;
		idx[0]   = it.index_first;
		idx[1]   = it.index_second;
		idx[2]   = it.index_third;
		idx[3]   = it.index_fourth;
		singles  = 0;
		n        = 0;
		cls_seen = '0;
		for (int i = 0; i < 4; i++) begin
			ent[i] = orb_table[idx[i]];
			singles += ent[i].single;
		end
		// more than one singly-occupied orbital: every matching permutation goes out
		multi = singles > 1;
		for (int k = 0; k < icr_pkg::NUM_ROWS; k++) begin
			if (cls_seen[PERM_CLS[k]] && !multi)
				continue;
			hit = 1'b1;
			for (int i = 0; i < 4; i++) begin
				sl = PERM_SLOTS[k][7-2*i -: 2];
				if (PERM_VIR[k][3-i]) begin
					hit &= ent[sl].virt;
					pos[i] = ent[sl].vir_pos;
				end else begin
					hit &= ent[sl].occupied;
					pos[i] = ent[sl].occ_pos;
				end
			end
			if (!hit)
				continue;
			cls_seen[PERM_CLS[k]] = 1'b1;
			run[n].integral_class    = PERM_CLS[k];
			run[n].out_index_first   = pos[0];
			run[n].out_index_second  = pos[1];
			run[n].out_index_third   = pos[2];
			run[n].out_index_fourth  = pos[3];
			run[n].out_integral_bits = it.integral_bits;
			run[n].last_of_run       = 1'b0;
			n++;
		end
		// last result of the run carries the marker; no match means no result at all
		if (n > 0)
			run[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			results_due.push_back(run[i]);
	endfunction

	// update the mirror for one accepted transaction
	function automatic void accept_transaction(input icr_pkg::in_item_t it);
		if (it.action == icr_pkg::ACT_LOAD) begin
			orb_table[it.load_orbital].occupied = it.load_occupied;
			orb_table[it.load_orbital].virt     = it.load_virtual;
			orb_table[it.load_orbital].single   = it.load_singly_occupied;
			orb_table[it.load_orbital].occ_pos  = it.load_occ_position;
			orb_table[it.load_orbital].vir_pos  = it.load_vir_position;
			if (!orb_loaded[it.load_orbital]) begin
				orb_loaded[it.load_orbital] = 1'b1;
				loaded_orbitals.push_back(it.load_orbital);
			end
		end else begin
			route_integral(it);
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// every field random, so unused fields toggle too
	function automatic icr_pkg::in_item_t random_fill();
		icr_pkg::in_item_t it;
		it.action               = 1'($urandom_range(0, 1));
		it.index_first          = 8'($urandom_range(0, 255));
		it.index_second         = 8'($urandom_range(0, 255));
		it.index_third          = 8'($urandom_range(0, 255));
		it.index_fourth         = 8'($urandom_range(0, 255));
		it.integral_bits        = {$urandom, $urandom};
		it.load_orbital         = 8'($urandom_range(0, 255));
		it.load_occupied        = 1'($urandom_range(0, 1));
		it.load_virtual         = 1'($urandom_range(0, 1));
		it.load_singly_occupied = 1'($urandom_range(0, 1));
		it.load_occ_position    = 8'($urandom_range(0, 255));
		it.load_vir_position    = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// offer one transaction and wait for its accept edge
	task automatic send_item(input icr_pkg::in_item_t it);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full);
		accept_transaction(it);
	endtask

	task automatic load_orbital(input logic [7:0] orb, input logic occ, input logic vir,
			input logic single, input logic [7:0] occ_pos, input logic [7:0] vir_pos);
		icr_pkg::in_item_t it;
		it                      = random_fill();
		it.action               = icr_pkg::ACT_LOAD;
		it.load_orbital         = orb;
		it.load_occupied        = occ;
		it.load_virtual         = vir;
		it.load_singly_occupied = single;
		it.load_occ_position    = occ_pos;
		it.load_vir_position    = vir_pos;
		send_item(it);
	endtask

	task automatic classify(input logic [7:0] p, input logic [7:0] q, input logic [7:0] r,
			input logic [7:0] s, input logic [63:0] bits);
		icr_pkg::in_item_t it;
		it               = random_fill();
		it.action        = icr_pkg::ACT_CLASSIFY;
		it.index_first   = p;
		it.index_second  = q;
		it.index_third   = r;
		it.index_fourth  = s;
		it.integral_bits = bits;
		send_item(it);
	endtask

	// stop offering and wait until every owed result has come out
	task automatic wait_for_drain();
		@(negedge clk);
		push <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// only orbitals already written are ever looked up
	function automatic logic [7:0] pick_loaded();
		return loaded_orbitals[$urandom_range(0, loaded_orbitals.size() - 1)];
	endfunction

	function automatic icr_pkg::in_item_t random_load();
		icr_pkg::in_item_t it;
		int                kind;
		it        = random_fill();
		it.action = icr_pkg::ACT_LOAD;
		kind      = $urandom_range(0, 9);
		// mostly a clean occupied or virtual orbital, sometimes both or neither
		it.load_occupied        = (kind <= 3) || (kind == 8);
		it.load_virtual         = (kind >= 4 && kind <= 7) || (kind == 8);
		it.load_singly_occupied = ($urandom_range(0, 3) == 0);
		return it;
	endfunction

	function automatic icr_pkg::in_item_t random_classify();
		icr_pkg::in_item_t it;
		logic [7:0]        idx [4];
		it        = random_fill();
		it.action = icr_pkg::ACT_CLASSIFY;
		idx[0]    = pick_loaded();
		// repeated indices are common in real integral lists
		for (int i = 1; i < 4; i++)
			idx[i] = ($urandom_range(0, 3) == 0) ? idx[$urandom_range(0, i - 1)] : pick_loaded();
		it.index_first  = idx[0];
		it.index_second = idx[1];
		it.index_third  = idx[2];
		it.index_fourth = idx[3];
		return it;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// one integral per class, the sixteen-result case, no match, overwrite
	task automatic test_directed();
		load_orbital(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'hFF); // occupied
		load_orbital(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 8'h00); // virtual, single
		load_orbital(8'hAA, 1'b1, 1'b1, 1'b1, 8'h55, 8'hAA); // both roles, single
		load_orbital(8'h55, 1'b0, 1'b0, 1'b0, 8'hAA, 8'h55); // neither role
		load_orbital(8'h0F, 1'b1, 1'b0, 1'b1, 8'h0F, 8'hF0); // occupied, single
		load_orbital(8'hF0, 1'b0, 1'b1, 1'b0, 8'hF0, 8'h0F); // virtual
		load_orbital(8'h33, 1'b1, 1'b1, 1'b0, 8'h3C, 8'hC3); // both roles, not single
		classify(8'h00, 8'h00, 8'h00, 8'h00, 64'h0);                    // oo|oo
		classify(8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);  // vv|vv
		classify(8'h00, 8'h0F, 8'hFF, 8'hF0, 64'h5555_5555_5555_5555);  // oo|vv
		classify(8'h00, 8'hFF, 8'h0F, 8'hF0, 64'hAAAA_AAAA_AAAA_AAAA);  // ov|ov
		classify(8'hFF, 8'h00, 8'h00, 8'h0F, 64'h0123_4567_89AB_CDEF);  // vo|oo
		classify(8'h00, 8'hFF, 8'hFF, 8'hF0, 64'hFEDC_BA98_7654_3210);  // ov|vv
		classify(8'hAA, 8'hAA, 8'hAA, 8'hAA, 64'h8000_0000_0000_0001);  // every row matches
		classify(8'h33, 8'h33, 8'h33, 8'h33, 64'h7FFF_FFFF_FFFF_FFFE);  // first per class only
		classify(8'h55, 8'h00, 8'h00, 8'h00, 64'hDEAD_BEEF_0000_FFFF);  // no match
		classify(8'h00, 8'h00, 8'h00, 8'h55, 64'h0000_FFFF_DEAD_BEEF);  // no match
		load_orbital(8'h00, 1'b0, 1'b1, 1'b1, 8'h11, 8'hEE);           // overwrite
		classify(8'h00, 8'h00, 8'h00, 8'h00, 64'h1);
	endtask

	// receiver holds off while classify transactions keep coming, so the block fills
	task automatic test_back_pressure();
		icr_pkg::in_item_t it;
		stall_cycles = 120;
		for (int n = 0; n < 24; n++) begin
			it = random_classify();
			if (n % 2 == 0) begin
				it.index_first  = 8'h33;
				it.index_second = 8'h33;
				it.index_third  = 8'h33;
				it.index_fourth = 8'h33;
			end
			send_item(it);
		end
	endtask

	// mixed loads and classifies; a calm stretch first, one full drain midway
	task automatic test_random(input int count);
		quiet = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (n == 60)
				quiet = 1'b0;
			if (n == count / 2)
				wait_for_drain();
			if ($urandom_range(0, 99) < 30)
				send_item(random_load());
			else
				send_item(random_classify());
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: random pops, long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_cycles > 0) begin
			pop <= 1'b0;
			stall_cycles <= stall_cycles - 1;
		end else if (quiet) begin
			pop <= 1'b1;
		end else begin
			pop <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		icr_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
			end else begin
				want = results_due.pop_front();
				check_field("integral_class", 64'(want.integral_class), 64'(result.integral_class));
				check_field("out_index_first", 64'(want.out_index_first),
					64'(result.out_index_first));
				check_field("out_index_second", 64'(want.out_index_second),
					64'(result.out_index_second));
				check_field("out_index_third", 64'(want.out_index_third),
					64'(result.out_index_third));
				check_field("out_index_fourth", 64'(want.out_index_fourth),
					64'(result.out_index_fourth));
				check_field("out_integral_bits", want.out_integral_bits,
					result.out_integral_bits);
				check_field("last_of_run", 64'(want.last_of_run), 64'(result.last_of_run));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("%0t: timeout with %0d results owed", $time, results_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_back_pressure();
		// sender pause until every owed result is out
		wait_for_drain();
		test_random(N_RANDOM);

		wait_for_drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
